>>> design/snt_pkg.sv
// shared types and codes for the sorted node table
package snt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_UNDER   = 3'd4;

  localparam int unsigned REG_MAX_KEYS = 0;
  localparam int unsigned REG_MIN_KEYS = 1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [6:0]  position;
    logic [6:0]  entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, start search
    logic srch_rd;    // issue read of mid
    logic srch_step;  // update lo/hi from read data
    logic hit_rd;     // read at lo
    logic hit_chk;    // evaluate hit
    logic mv_rd;      // read source slot of a move
    logic mv_wr;      // write moved entry
    logic put_wr;     // write new entry at pos
    logic finish;     // update count, build result
  } snt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_done;
    logic mv_done;
    logic do_ins;
    logic do_del;
  } snt_sts_t;

endpackage

>>> design/snt_ram.sv
// generic single port ram with registered read
module snt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/snt_ctrl.sv
// sequencer for search, move and write phases
module snt_ctrl
  import snt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  snt_sts_t sts,
  output snt_cmd_t cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_SSTEP = 9'b000000100,
    S_HRD   = 9'b000001000,
    S_HCHK  = 9'b000010000,
    S_MRD   = 9'b000100000,
    S_MWR   = 9'b001000000,
    S_PUT   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.srch_done) begin
          cmd.hit_rd = 1'b1;
          state_nxt  = S_HCHK;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SSTEP;
        end
      end
      S_SSTEP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRD;
      end
      S_HRD: begin
        cmd.hit_rd = 1'b1;
        state_nxt  = S_HCHK;
      end
      S_HCHK: begin
        cmd.hit_chk = 1'b1;
        state_nxt   = S_MRD;
      end
      S_MRD: begin
        if (!(sts.do_ins || sts.do_del) || sts.mv_done) begin
          state_nxt = sts.do_ins ? S_PUT : S_FIN;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MRD;
      end
      S_PUT: begin
        cmd.put_wr = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

>>> design/snt_dp.sv
// node storage, search bounds, move pointer and result register
module snt_dp
  import snt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic [6:0] max_keys,
  input  logic [5:0] min_keys,
  input  snt_cmd_t  cmd,
  output snt_sts_t  sts,
  output out_item_t out_data
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CW-1:0]         cnt_r, lo_r, hi_r, ptr_r;
  logic                  hit_r, ins_r, del_r;
  logic [2:0]            stat_r;
  logic [VALUE_BITS-1:0] fval_r;
  out_item_t             res_r;

  logic [CW-1:0]         mid;
  logic [AW-1:0]         addr;
  logic                  we;
  logic [KEY_BITS-1:0]   kw, kr;
  logic [VALUE_BITS-1:0] vw, vr;
  logic                  hit;
  logic                  is_find;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign hit     = (lo_r < cnt_r) && (kr == key_r);
  assign is_find = (op_r == OP_FIND) || (op_r == OP_SPARE);

  // insert moves ptr-1 -> ptr downward from count, delete moves ptr+1 -> ptr
  always_comb begin
    addr = '0;
    we   = 1'b0;
    kw   = kr;
    vw   = vr;
    if (cmd.srch_rd) begin
      addr = mid[AW-1:0];
    end else if (cmd.hit_rd) begin
      addr = lo_r[AW-1:0];
    end else if (cmd.mv_rd) begin
      addr = ins_r ? AW'(ptr_r - 1'b1) : AW'(ptr_r + 1'b1);
    end else if (cmd.mv_wr) begin
      addr = ptr_r[AW-1:0];
      we   = 1'b1;
    end else if (cmd.put_wr) begin
      addr = lo_r[AW-1:0];
      we   = 1'b1;
      kw   = key_r;
      vw   = val_r;
    end
  end

  snt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr)
  );
  snt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(we), .addr(addr), .wdata(vw), .rdata(vr)
  );

  assign sts.srch_done = (lo_r >= hi_r);
  assign sts.do_ins    = ins_r;
  assign sts.do_del    = del_r;
  assign sts.mv_done   = ins_r ? (ptr_r <= lo_r) : (CW'(ptr_r + 1'b1) >= cnt_r);
  assign out_data      = res_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      key_r <= KEY_BITS'(in_data.key);
      val_r <= VALUE_BITS'(in_data.value);
      lo_r  <= '0;
      hi_r  <= cnt_r;
    end
    if (cmd.srch_step) begin
      if (kr < key_r) begin
        lo_r <= CW'(hi_r == lo_r ? lo_r : lo_r + ((hi_r - lo_r) >> 1) + 1'b1);
      end else begin
        hi_r <= lo_r + ((hi_r - lo_r) >> 1);
      end
    end
    if (cmd.hit_chk) begin
      hit_r  <= hit;
      fval_r <= '0;
      stat_r <= ST_OK;
      ins_r  <= 1'b0;
      del_r  <= 1'b0;
      ptr_r  <= hit ? lo_r : cnt_r;
      case (op_r)
        OP_INSERT: begin
          if ((32'(cnt_r) + 32'd1 > 32'(max_keys)) || (32'(cnt_r) >= CAPACITY)) begin
            stat_r <= ST_FULL;
          end else if (hit) begin
            stat_r <= ST_DUP;
          end else begin
            ins_r <= 1'b1;
            ptr_r <= cnt_r;
          end
        end
        OP_DELETE: begin
          if (!hit) begin
            stat_r <= ST_MISSING;
          end else if (32'(cnt_r) <= 32'(min_keys)) begin
            stat_r <= ST_UNDER;
          end else begin
            del_r <= 1'b1;
            ptr_r <= lo_r;
          end
        end
        default: begin
          if (hit) begin
            fval_r <= vr;
          end else begin
            stat_r <= ST_MISSING;
          end
        end
      endcase
    end
    if (cmd.mv_wr) begin
      ptr_r <= ins_r ? CW'(ptr_r - 1'b1) : CW'(ptr_r + 1'b1);
    end
    if (cmd.finish) begin
      res_r.status      <= stat_r;
      res_r.found_value <= (is_find && hit_r) ? 32'(fval_r) : 32'd0;
      res_r.position    <= 7'(lo_r);
      res_r.entry_count <= 7'(ins_r ? cnt_r + 1'b1 : del_r ? cnt_r - 1'b1 : cnt_r);
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.finish) begin
      cnt_r <= ins_r ? CW'(cnt_r + 1'b1) : del_r ? CW'(cnt_r - 1'b1) : cnt_r;
    end
  end
endmodule

>>> design/sorted_node_table_top.sv
// sorted b-tree leaf node: insert, delete and find on a sorted array
// sequence: binary search over the stored keys, hit check, a read and a write per moved
//   entry, then the new entry's write for an insert, then the result
// throughput: one request at a time; the next is taken the cycle its result leaves; the
//   single memory port sets the move rate
// reset: synchronous active low; count clears to zero, max_keys 64, min_keys 32
module sorted_node_table_top
  import snt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [6:0] max_keys_r;
  logic [5:0] min_keys_r;
  snt_cmd_t   cmd;
  snt_sts_t   sts;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_keys_r <= 7'd64;
      min_keys_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == 1'(REG_MAX_KEYS)) begin
        max_keys_r <= cfg_pwdata[6:0];
      end else begin
        min_keys_r <= cfg_pwdata[5:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == 1'(REG_MIN_KEYS)) begin
      cfg_prdata[5:0] = min_keys_r;
    end else begin
      cfg_prdata[6:0] = max_keys_r;
    end
  end

  snt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  snt_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .max_keys(max_keys_r),
    .min_keys(min_keys_r), .cmd(cmd), .sts(sts), .out_data(out_data)
  );
endmodule
